// File: rtl/quintic_trajectory_generator_top_assert.svh
// Assertion macros for the quintic trajectory generator.
// No dependencies; included by the top level, the only file that carries concurrent assertions.
`ifndef QUINTIC_TRAJECTORY_GENERATOR_TOP_ASSERT_SVH
`define QUINTIC_TRAJECTORY_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define QTG_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qtg: assertion failed");

// Next-cycle implication, disabled during reset.
`define QTG_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qtg: assertion failed");

`endif

// File: rtl/qtg_pkg.sv
// Shared types, constants and the microprogram of the quintic trajectory generator.
// No dependencies; used by qtg_cfg_if, qtg_alu and the top level.
package qtg_pkg;

    localparam int VAL_W      = 60;
    localparam int DIV_W      = 87;
    localparam int DIV_STEPS  = 87;
    localparam int S_W        = 31;
    localparam int PC_W       = 7;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [VAL_W-1:0] val_t;

    // 2^58, the clamp limit of every intermediate
    localparam logic [58:0] VMAX_MAG = 59'd288230376151711744;

    localparam logic [1:0] OPER_TICK   = 2'd0;
    localparam logic [1:0] OPER_PLAN   = 2'd1;
    localparam logic [1:0] OPER_CANCEL = 2'd2;

    localparam logic [31:0] SAMPLE_PERIOD_RESET = 32'd268435;
    localparam logic [31:0] MOVE_DURATION_RESET = 32'd268435456;

    localparam logic [PC_W-1:0] PLAN_START = 7'd0;
    localparam logic [PC_W-1:0] EVAL_START = 7'd43;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_PERIOD,
        REG_MOVE_DURATION,
        REG_START_POSITION,
        REG_START_VELOCITY,
        REG_START_ACCEL,
        REG_END_POSITION,
        REG_END_VELOCITY,
        REG_END_ACCEL
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_MAC,
        OP_MULS,
        OP_HALF,
        OP_DIV,
        OP_ST
    } op_t;

    typedef enum logic [3:0] {
        SRC_ACC,
        SRC_COEF,
        SRC_D1,
        SRC_D2,
        SRC_D3,
        SRC_H3,
        SRC_SP,
        SRC_SV,
        SRC_SA,
        SRC_EP,
        SRC_EV,
        SRC_EA
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_COEF,
        DST_D1,
        DST_D2,
        DST_D3,
        DST_H3,
        DST_POS,
        DST_VEL,
        DST_ACC
    } dst_t;

    // Multiply by dur (B_T) or normalized time (B_S); divide by dur
    typedef enum logic {
        B_T,
        B_S
    } bsel_t;

    typedef struct packed {
        op_t               op;
        src_t              src;
        dst_t              dst;
        logic [2:0]        idx;
        logic signed [5:0] k;
        logic              clr;
        bsel_t             bsel;
        logic              last;
    } uop_t;

    typedef struct packed {
        logic              start;
        op_t               op;
        logic signed [5:0] k;
        logic              clr;
        bsel_t             bsel;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    function automatic val_t clamp_val(logic signed [67:0] x);
        logic signed [67:0] lim;
        lim = 68'({9'b0, VMAX_MAG});
        if (x > lim) begin
            return val_t'(lim);
        end
        if (x < -lim) begin
            return val_t'(-lim);
        end
        return val_t'(x);
    endfunction

    function automatic val_t apply_sign(logic neg, logic [58:0] mag);
        val_t v;
        v = val_t'({1'b0, mag});
        return neg ? -v : v;
    endfunction

    function automatic val_t sx32(logic [31:0] x);
        return val_t'($signed(x));
    endfunction

    function automatic logic [31:0] sat32(val_t x);
        if (x > val_t'(32'sh7fffffff)) begin
            return 32'h7fffffff;
        end
        if (x < val_t'(-33'sh80000000)) begin
            return 32'h80000000;
        end
        return x[31:0];
    endfunction

    function automatic uop_t mk(op_t op, src_t src, logic [2:0] idx, logic signed [5:0] k,
                                logic clr, bsel_t bsel, dst_t dst, logic last);
        uop_t u;
        u.op   = op;
        u.src  = src;
        u.dst  = dst;
        u.idx  = idx;
        u.k    = k;
        u.clr  = clr;
        u.bsel = bsel;
        u.last = last;
        return u;
    endfunction

    function automatic uop_t mac(src_t src, logic [2:0] idx, logic signed [5:0] k, logic clr);
        return mk(OP_MAC, src, idx, k, clr, B_T, DST_NONE, 1'b0);
    endfunction

    function automatic uop_t muls(bsel_t b);
        return mk(OP_MULS, SRC_ACC, 3'd0, 6'sd0, 1'b0, b, DST_NONE, 1'b0);
    endfunction

    function automatic uop_t half_op();
        return mk(OP_HALF, SRC_ACC, 3'd0, 6'sd0, 1'b0, B_T, DST_NONE, 1'b0);
    endfunction

    function automatic uop_t div_op(bsel_t b);
        return mk(OP_DIV, SRC_ACC, 3'd0, 6'sd0, 1'b0, b, DST_NONE, 1'b0);
    endfunction

    function automatic uop_t st_op(dst_t d, logic [2:0] idx, logic last);
        return mk(OP_ST, SRC_ACC, idx, 6'sd0, 1'b0, B_T, d, last);
    endfunction

    // Plan at PLAN_START, tick evaluation at EVAL_START
    function automatic uop_t uop_at(logic [PC_W-1:0] pc);
        uop_t u;
        u = st_op(DST_NONE, 3'd0, 1'b1);
        case (pc)
            // a0, a1, a2
            7'd0:  u = mac(SRC_SP, 3'd0, 6'sd1, 1'b1);
            7'd1:  u = st_op(DST_COEF, 3'd0, 1'b0);
            7'd2:  u = mac(SRC_SV, 3'd0, 6'sd1, 1'b1);
            7'd3:  u = muls(B_T);
            7'd4:  u = st_op(DST_COEF, 3'd1, 1'b0);
            7'd5:  u = mac(SRC_SA, 3'd0, 6'sd1, 1'b1);
            7'd6:  u = muls(B_T);
            7'd7:  u = muls(B_T);
            7'd8:  u = half_op();
            7'd9:  u = st_op(DST_COEF, 3'd2, 1'b0);
            // d1
            7'd10: u = mac(SRC_COEF, 3'd0, 6'sd1, 1'b1);
            7'd11: u = mac(SRC_COEF, 3'd1, 6'sd1, 1'b0);
            7'd12: u = mac(SRC_COEF, 3'd2, 6'sd1, 1'b0);
            7'd13: u = mac(SRC_ACC, 3'd0, -6'sd1, 1'b1);
            7'd14: u = mac(SRC_EP, 3'd0, 6'sd1, 1'b0);
            7'd15: u = st_op(DST_D1, 3'd0, 1'b0);
            // d2
            7'd16: u = mac(SRC_COEF, 3'd1, 6'sd1, 1'b1);
            7'd17: u = mac(SRC_COEF, 3'd2, 6'sd2, 1'b0);
            7'd18: u = mac(SRC_ACC, 3'd0, -6'sd1, 1'b1);
            7'd19: u = st_op(DST_D2, 3'd0, 1'b0);
            7'd20: u = mac(SRC_EV, 3'd0, 6'sd1, 1'b1);
            7'd21: u = muls(B_T);
            7'd22: u = mac(SRC_D2, 3'd0, 6'sd1, 1'b0);
            7'd23: u = st_op(DST_D2, 3'd0, 1'b0);
            // d3 and its half
            7'd24: u = mac(SRC_EA, 3'd0, 6'sd1, 1'b1);
            7'd25: u = muls(B_T);
            7'd26: u = muls(B_T);
            7'd27: u = mac(SRC_COEF, 3'd2, -6'sd2, 1'b0);
            7'd28: u = st_op(DST_D3, 3'd0, 1'b0);
            7'd29: u = half_op();
            7'd30: u = st_op(DST_H3, 3'd0, 1'b0);
            // a3, a4, a5
            7'd31: u = mac(SRC_D1, 3'd0, 6'sd10, 1'b1);
            7'd32: u = mac(SRC_D2, 3'd0, -6'sd4, 1'b0);
            7'd33: u = mac(SRC_H3, 3'd0, 6'sd1, 1'b0);
            7'd34: u = st_op(DST_COEF, 3'd3, 1'b0);
            7'd35: u = mac(SRC_D1, 3'd0, -6'sd15, 1'b1);
            7'd36: u = mac(SRC_D2, 3'd0, 6'sd7, 1'b0);
            7'd37: u = mac(SRC_D3, 3'd0, -6'sd1, 1'b0);
            7'd38: u = st_op(DST_COEF, 3'd4, 1'b0);
            7'd39: u = mac(SRC_D1, 3'd0, 6'sd6, 1'b1);
            7'd40: u = mac(SRC_D2, 3'd0, -6'sd3, 1'b0);
            7'd41: u = mac(SRC_H3, 3'd0, 6'sd1, 1'b0);
            7'd42: u = st_op(DST_COEF, 3'd5, 1'b1);
            // normalized time, then position
            7'd43: u = div_op(B_S);
            7'd44: u = mac(SRC_COEF, 3'd5, 6'sd1, 1'b1);
            7'd45: u = muls(B_S);
            7'd46: u = mac(SRC_COEF, 3'd4, 6'sd1, 1'b0);
            7'd47: u = muls(B_S);
            7'd48: u = mac(SRC_COEF, 3'd3, 6'sd1, 1'b0);
            7'd49: u = muls(B_S);
            7'd50: u = mac(SRC_COEF, 3'd2, 6'sd1, 1'b0);
            7'd51: u = muls(B_S);
            7'd52: u = mac(SRC_COEF, 3'd1, 6'sd1, 1'b0);
            7'd53: u = muls(B_S);
            7'd54: u = mac(SRC_COEF, 3'd0, 6'sd1, 1'b0);
            7'd55: u = st_op(DST_POS, 3'd0, 1'b0);
            // velocity
            7'd56: u = mac(SRC_COEF, 3'd5, 6'sd5, 1'b1);
            7'd57: u = muls(B_S);
            7'd58: u = mac(SRC_COEF, 3'd4, 6'sd4, 1'b0);
            7'd59: u = muls(B_S);
            7'd60: u = mac(SRC_COEF, 3'd3, 6'sd3, 1'b0);
            7'd61: u = muls(B_S);
            7'd62: u = mac(SRC_COEF, 3'd2, 6'sd2, 1'b0);
            7'd63: u = muls(B_S);
            7'd64: u = mac(SRC_COEF, 3'd1, 6'sd1, 1'b0);
            7'd65: u = div_op(B_T);
            7'd66: u = st_op(DST_VEL, 3'd0, 1'b0);
            // acceleration
            7'd67: u = mac(SRC_COEF, 3'd5, 6'sd20, 1'b1);
            7'd68: u = muls(B_S);
            7'd69: u = mac(SRC_COEF, 3'd4, 6'sd12, 1'b0);
            7'd70: u = muls(B_S);
            7'd71: u = mac(SRC_COEF, 3'd3, 6'sd6, 1'b0);
            7'd72: u = muls(B_S);
            7'd73: u = mac(SRC_COEF, 3'd2, 6'sd2, 1'b0);
            7'd74: u = div_op(B_T);
            7'd75: u = div_op(B_T);
            7'd76: u = st_op(DST_ACC, 3'd0, 1'b1);
            default: u = st_op(DST_NONE, 3'd0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

// File: rtl/qtg_cmd_if.sv
// Command channel of the quintic trajectory generator.
// Depends on nothing; carries operation and hold position with valid/ready.
interface qtg_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic signed [31:0] hold_position;

    modport source (output valid, operation, hold_position, input ready);
    modport sink   (input valid, operation, hold_position, output ready);
endinterface

// File: rtl/qtg_rsp_if.sv
// Result channel of the quintic trajectory generator.
// Depends on nothing; carries the motion state and flags with valid/ready.
interface qtg_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic               profile_valid;
    logic               profile_active;
    logic               status;

    modport source (output valid, position, velocity, acceleration, profile_valid,
                    profile_active, status, input ready);
    modport sink   (input valid, position, velocity, acceleration, profile_valid,
                    profile_active, status, output ready);
endinterface

// File: rtl/qtg_cfg_if.sv
// Configuration write channel of the quintic trajectory generator.
// Depends on qtg_pkg for the register index width.
interface qtg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [qtg_pkg::CFG_IDX_W-1:0]    index;
    logic [31:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/qtg_alu.sv
// Shared arithmetic unit: clamped multiply-add, halving, fixed-point multiply
// (two 32x32 passes) and a bit-serial restoring divider. Depends on qtg_pkg.
module qtg_alu (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qtg_pkg::alu_cmd_t    cmd,
    input  qtg_pkg::val_t        opnd,
    input  logic [31:0]          dur,
    input  logic [31:0]          elapsed,
    output qtg_pkg::val_t        acc,
    output qtg_pkg::alu_stat_t   stat
);

    qtg_pkg::val_t              acc_reg;
    logic [qtg_pkg::S_W-1:0]    s_reg;
    logic [35:0]                lo_reg;
    logic [qtg_pkg::DIV_W-1:0]  num_reg;
    logic [31:0]                rem_reg;
    logic [6:0]                 cnt_reg;
    logic                       busy_reg;
    qtg_pkg::op_t               op_reg;
    qtg_pkg::bsel_t             bsel_reg;

    logic signed [65:0]         mac_prod;
    qtg_pkg::val_t              mac_term;
    logic signed [60:0]         mac_sum;
    qtg_pkg::val_t              mac_res;
    qtg_pkg::val_t              half_tmp;
    qtg_pkg::val_t              neg_acc;
    logic [58:0]                m_abs;
    qtg_pkg::bsel_t             mul_bsel;
    logic [31:0]                mul_a;
    logic [31:0]                b_val;
    logic [63:0]                mul_prod;
    logic [35:0]                lo_val;
    logic [63:0]                hi_sh;
    logic [63:0]                mul_sum;
    logic [58:0]                mul_mag;
    logic [32:0]                rem_sh;
    logic [32:0]                rem_diff;
    logic                       ge;
    logic [31:0]                rem_next;
    logic [qtg_pkg::DIV_W-1:0]  quo;
    logic [58:0]                div_mag;
    logic                       div_last;

    assign mac_prod = 66'(opnd) * 66'($signed(cmd.k));
    assign mac_term = qtg_pkg::clamp_val(68'(mac_prod));
    assign mac_sum  = 61'(cmd.clr ? qtg_pkg::val_t'(0) : acc_reg) + 61'(mac_term);
    assign mac_res  = qtg_pkg::clamp_val(68'(mac_sum));

    // halve with truncation toward zero
    assign half_tmp = acc_reg + qtg_pkg::val_t'({1'b0, acc_reg[qtg_pkg::VAL_W-1]});

    assign neg_acc = -acc_reg;
    assign m_abs   = acc_reg[qtg_pkg::VAL_W-1] ? neg_acc[58:0] : acc_reg[58:0];

    // low half of the magnitude on the issue cycle, high half on the next
    assign mul_bsel = busy_reg ? bsel_reg : cmd.bsel;
    assign mul_a    = busy_reg ? {5'b0, m_abs[58:32]} : m_abs[31:0];
    assign b_val    = (mul_bsel == qtg_pkg::B_S) ? {1'b0, s_reg} : dur;
    assign mul_prod = mul_a * b_val;
    assign lo_val   = (cmd.bsel == qtg_pkg::B_S) ? 36'(mul_prod >> 30) : 36'(mul_prod >> 28);
    assign hi_sh    = (bsel_reg == qtg_pkg::B_S) ? (mul_prod << 2) : (mul_prod << 4);
    assign mul_sum  = hi_sh + 64'(lo_reg);
    assign mul_mag  = (mul_sum > {5'b0, qtg_pkg::VMAX_MAG}) ? qtg_pkg::VMAX_MAG
                                                              : mul_sum[58:0];

    assign rem_sh   = {rem_reg, num_reg[qtg_pkg::DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, dur};
    assign ge       = (rem_sh >= {1'b0, dur});
    assign rem_next = ge ? rem_diff[31:0] : rem_sh[31:0];
    assign quo      = {num_reg[qtg_pkg::DIV_W-2:0], ge};
    assign div_mag  = (quo > {28'b0, qtg_pkg::VMAX_MAG}) ? qtg_pkg::VMAX_MAG : quo[58:0];
    assign div_last = (cnt_reg == 7'(qtg_pkg::DIV_STEPS - 1));

    assign acc       = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = (cmd.start && (cmd.op != qtg_pkg::OP_MULS)
                                  && (cmd.op != qtg_pkg::OP_DIV))
                     || (busy_reg && ((op_reg == qtg_pkg::OP_MULS) || div_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= qtg_pkg::OP_MAC;
            bsel_reg <= qtg_pkg::B_T;
        end
        else if (cmd.start)
        begin
            if ((cmd.op == qtg_pkg::OP_MULS) || (cmd.op == qtg_pkg::OP_DIV))
            begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                bsel_reg <= cmd.bsel;
                cnt_reg  <= '0;
            end
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            if ((op_reg == qtg_pkg::OP_MULS) || div_last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            case (cmd.op)
                qtg_pkg::OP_MAC:  acc_reg <= mac_res;
                qtg_pkg::OP_HALF: acc_reg <= half_tmp >>> 1;
                qtg_pkg::OP_MULS: lo_reg  <= lo_val;
                qtg_pkg::OP_DIV:
                begin
                    if (cmd.bsel == qtg_pkg::B_S)
                    begin
                        num_reg <= {25'b0, elapsed, 30'b0};
                    end
                    else
                    begin
                        num_reg <= {m_abs, 28'b0};
                    end
                    rem_reg <= '0;
                end
                default: ;
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                qtg_pkg::OP_MULS:
                begin
                    acc_reg <= qtg_pkg::apply_sign(acc_reg[qtg_pkg::VAL_W-1], mul_mag);
                end
                qtg_pkg::OP_DIV:
                begin
                    num_reg <= quo;
                    rem_reg <= rem_next;
                    if (div_last)
                    begin
                        if (bsel_reg == qtg_pkg::B_S)
                        begin
                            s_reg <= quo[qtg_pkg::S_W-1:0];
                        end
                        else
                        begin
                            acc_reg <= qtg_pkg::apply_sign(acc_reg[qtg_pkg::VAL_W-1],
                                                           div_mag);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/quintic_trajectory_generator_top.sv
// Quintic trajectory generator. One command transaction in gives one result
// transaction out; the block takes no new command until the current one is done.
// A cancel, an idle tick, an unused operation or a rejected plan runs no microsteps;
// an accepted plan runs 43 microsteps, six of them multiplies. An active tick runs
// four bit-serial divisions in the shared unit (normalized time, velocity once,
// acceleration twice) next to 30 more microsteps, twelve of them multiplies. A
// finished result waits in the output register, and the next command is taken
// while it waits.
// Depends on qtg_pkg, the channel interfaces, qtg_alu and the assertion header.
`include "quintic_trajectory_generator_top_assert.svh"

module quintic_trajectory_generator_top (
    input  logic      clk,
    input  logic      rst_n,
    qtg_cfg_if.sink   cfg,
    qtg_cmd_if.sink   cmd,
    qtg_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic [qtg_pkg::PC_W-1:0]  pc_reg;
    logic                      plan_reg;

    logic [31:0] sp_reg, md_reg, spos_reg, svel_reg, sacc_reg, epos_reg, evel_reg, eacc_reg;
    logic [31:0] elapsed_reg, latched_reg, pos_reg, vel_reg, accl_reg;
    logic        valid_reg, active_reg, status_reg;

    qtg_pkg::val_t coef_reg [6];
    qtg_pkg::val_t d1_reg, d2_reg, d3_reg, h3_reg;

    logic        out_valid_reg;
    logic [31:0] out_pos_reg, out_vel_reg, out_acc_reg;
    logic        out_pv_reg, out_pa_reg, out_st_reg;

    qtg_pkg::uop_t      uop;
    qtg_pkg::alu_cmd_t  alu_cmd;
    qtg_pkg::alu_stat_t alu_stat;
    qtg_pkg::val_t      alu_acc;
    qtg_pkg::val_t      opnd;
    logic [31:0]        dur;
    logic [32:0]        tick_sum;
    logic               accept;
    logic               step_done;
    logic               plan_reject;
    logic               run_start;

    assign uop = qtg_pkg::uop_at(pc_reg);

    always_comb
    begin
        case (uop.src)
            qtg_pkg::SRC_ACC:  opnd = alu_acc;
            qtg_pkg::SRC_COEF: opnd = coef_reg[uop.idx];
            qtg_pkg::SRC_D1:   opnd = d1_reg;
            qtg_pkg::SRC_D2:   opnd = d2_reg;
            qtg_pkg::SRC_D3:   opnd = d3_reg;
            qtg_pkg::SRC_H3:   opnd = h3_reg;
            qtg_pkg::SRC_SP:   opnd = qtg_pkg::sx32(spos_reg);
            qtg_pkg::SRC_SV:   opnd = qtg_pkg::sx32(svel_reg);
            qtg_pkg::SRC_SA:   opnd = qtg_pkg::sx32(sacc_reg);
            qtg_pkg::SRC_EP:   opnd = qtg_pkg::sx32(epos_reg);
            qtg_pkg::SRC_EV:   opnd = qtg_pkg::sx32(evel_reg);
            qtg_pkg::SRC_EA:   opnd = qtg_pkg::sx32(eacc_reg);
            default:           opnd = alu_acc;
        endcase
    end

    assign dur = plan_reg ? md_reg : latched_reg;

    assign alu_cmd.start = (state_reg == S_RUN) && !alu_stat.busy;
    assign alu_cmd.op    = uop.op;
    assign alu_cmd.k     = uop.k;
    assign alu_cmd.clr   = uop.clr;
    assign alu_cmd.bsel  = uop.bsel;

    qtg_alu u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (alu_cmd),
        .opnd    (opnd),
        .dur     (dur),
        .elapsed (elapsed_reg),
        .acc     (alu_acc),
        .stat    (alu_stat)
    );

    assign step_done = (state_reg == S_RUN) && alu_stat.done;
    assign accept    = cmd.valid && cmd.ready;
    assign tick_sum  = {1'b0, elapsed_reg} + {1'b0, sp_reg};

    assign plan_reject = (md_reg == 32'd0) || (sp_reg == 32'd0);
    assign run_start   = ((cmd.operation == qtg_pkg::OPER_TICK) && valid_reg && active_reg)
                      || ((cmd.operation == qtg_pkg::OPER_PLAN) && !plan_reject);

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid          = out_valid_reg;
    assign rsp.position       = out_pos_reg;
    assign rsp.velocity       = out_vel_reg;
    assign rsp.acceleration   = out_acc_reg;
    assign rsp.profile_valid  = out_pv_reg;
    assign rsp.profile_active = out_pa_reg;
    assign rsp.status         = out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= qtg_pkg::PLAN_START;
            plan_reg      <= 1'b0;
            sp_reg        <= qtg_pkg::SAMPLE_PERIOD_RESET;
            md_reg        <= qtg_pkg::MOVE_DURATION_RESET;
            spos_reg      <= '0;
            svel_reg      <= '0;
            sacc_reg      <= '0;
            epos_reg      <= '0;
            evel_reg      <= '0;
            eacc_reg      <= '0;
            elapsed_reg   <= '0;
            latched_reg   <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            accl_reg      <= '0;
            valid_reg     <= 1'b0;
            active_reg    <= 1'b0;
            status_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (qtg_pkg::cfg_idx_t'(cfg.index))
                    qtg_pkg::REG_SAMPLE_PERIOD:  sp_reg   <= cfg.data;
                    qtg_pkg::REG_MOVE_DURATION:  md_reg   <= cfg.data;
                    qtg_pkg::REG_START_POSITION: spos_reg <= cfg.data;
                    qtg_pkg::REG_START_VELOCITY: svel_reg <= cfg.data;
                    qtg_pkg::REG_START_ACCEL:    sacc_reg <= cfg.data;
                    qtg_pkg::REG_END_POSITION:   epos_reg <= cfg.data;
                    qtg_pkg::REG_END_VELOCITY:   evel_reg <= cfg.data;
                    qtg_pkg::REG_END_ACCEL:      eacc_reg <= cfg.data;
                    default: ;
                endcase
            end

            // load a waiting result once the output register is free
            if ((state_reg == S_OUT) && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= (cmd.operation == qtg_pkg::OPER_PLAN) && plan_reject;
                        state_reg  <= run_start ? S_RUN : S_OUT;
                        case (cmd.operation)
                            qtg_pkg::OPER_TICK:
                            begin
                                if (valid_reg && active_reg)
                                begin
                                    // clamp at the end of the move
                                    if (tick_sum >= {1'b0, latched_reg})
                                    begin
                                        elapsed_reg <= latched_reg;
                                        active_reg  <= 1'b0;
                                    end
                                    else
                                    begin
                                        elapsed_reg <= tick_sum[31:0];
                                    end
                                    plan_reg <= 1'b0;
                                    pc_reg   <= qtg_pkg::EVAL_START;
                                end
                            end
                            qtg_pkg::OPER_PLAN:
                            begin
                                if (!plan_reject)
                                begin
                                    plan_reg <= 1'b1;
                                    pc_reg   <= qtg_pkg::PLAN_START;
                                end
                            end
                            qtg_pkg::OPER_CANCEL:
                            begin
                                valid_reg   <= 1'b0;
                                active_reg  <= 1'b0;
                                elapsed_reg <= '0;
                                latched_reg <= '0;
                                pos_reg     <= cmd.hold_position;
                                vel_reg     <= '0;
                                accl_reg    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RUN:
                begin
                    if (step_done)
                    begin
                        if (uop.op == qtg_pkg::OP_ST)
                        begin
                            case (uop.dst)
                                qtg_pkg::DST_POS: pos_reg  <= qtg_pkg::sat32(alu_acc);
                                qtg_pkg::DST_VEL: vel_reg  <= qtg_pkg::sat32(alu_acc);
                                qtg_pkg::DST_ACC: accl_reg <= qtg_pkg::sat32(alu_acc);
                                default: ;
                            endcase
                        end
                        if (uop.last)
                        begin
                            if (plan_reg)
                            begin
                                latched_reg <= md_reg;
                                elapsed_reg <= '0;
                                pos_reg     <= spos_reg;
                                vel_reg     <= svel_reg;
                                accl_reg    <= sacc_reg;
                                valid_reg   <= 1'b1;
                                active_reg  <= 1'b1;
                            end
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            pc_reg <= pc_reg + 7'd1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_done && (uop.op == qtg_pkg::OP_ST))
        begin
            case (uop.dst)
                qtg_pkg::DST_COEF: coef_reg[uop.idx] <= alu_acc;
                qtg_pkg::DST_D1:   d1_reg <= alu_acc;
                qtg_pkg::DST_D2:   d2_reg <= alu_acc;
                qtg_pkg::DST_D3:   d3_reg <= alu_acc;
                qtg_pkg::DST_H3:   h3_reg <= alu_acc;
                default: ;
            endcase
        end
        if ((state_reg == S_OUT) && (!out_valid_reg || rsp.ready))
        begin
            out_pos_reg <= pos_reg;
            out_vel_reg <= vel_reg;
            out_acc_reg <= accl_reg;
            out_pv_reg  <= valid_reg;
            out_pa_reg  <= active_reg;
            out_st_reg  <= status_reg;
        end
    end

    `QTG_ASSERT_IMP(a_busy_in_run, clk, rst_n, alu_stat.busy, state_reg == S_RUN)
    `QTG_ASSERT_NXT(a_one_at_a_time, clk, rst_n, accept, !cmd.ready)
    `QTG_ASSERT_IMP(a_time_bounded, clk, rst_n, 1'b1, elapsed_reg <= latched_reg)
    `QTG_ASSERT_IMP(a_active_valid, clk, rst_n, active_reg, valid_reg)

endmodule
